@@ rtl/dfhe_pkg.sv @@
// Shared types, constants and helpers of the fixed-Huffman DEFLATE encoder.
// Used by dfhe_front, dfhe_queue, dfhe_back and the top level.
// No dependencies.
`default_nettype none

package dfhe_pkg;

  localparam int QUEUE_DEPTH_DEF = 4;

  localparam int BITS_W = 18;  // longest symbol: 5-bit distance code + 13 extra bits
  localparam int LEN_W  = 5;
  localparam int ACC_W  = 25;  // 7 leftover bits + longest symbol
  localparam int CNT_W  = 5;

  // Input symbol kinds
  localparam logic [2:0] KIND_START    = 3'd0;
  localparam logic [2:0] KIND_LITERAL  = 3'd1;
  localparam logic [2:0] KIND_LENGTH   = 3'd2;
  localparam logic [2:0] KIND_DISTANCE = 3'd3;
  localparam logic [2:0] KIND_FINISH   = 3'd4;

  // zlib header and block header
  localparam logic [7:0] ZLIB_CMF = 8'h78;
  localparam logic [7:0] ZLIB_FLG = 8'h5E;
  localparam logic [ACC_W-1:0] BLOCK_HDR_BITS = ACC_W'(3'b011);  // BFINAL=1, BTYPE=01
  localparam logic [CNT_W-1:0] BLOCK_HDR_LEN  = CNT_W'(3);
  localparam logic [CNT_W-1:0] EOB_LEN        = CNT_W'(7);      // end-of-block is all zeros

  typedef enum logic [1:0] {
    OP_BITS,
    OP_START,
    OP_FINISH
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [BITS_W-1:0] bits;   // LSB goes out first
    logic [LEN_W-1:0]  len;
    logic              err;    // sticky error flag as of this symbol
    logic [31:0]       adler;
  } entry_t;

  // Reverse a 9-bit Huffman code so its MSB lands at bit 0.
  function automatic logic [8:0] rev9(input logic [8:0] code);
    logic [8:0] r;
    for (int i = 0; i < 9; i++) begin
      r[i] = code[8-i];
    end
    return r;
  endfunction

  // Number of significant bits in v.
  function automatic logic [4:0] bit_len16(input logic [15:0] v);
    logic [4:0] n;
    n = 5'd0;
    for (int i = 0; i < 16; i++) begin
      if (v[i]) begin
        n = 5'(i + 1);
      end
    end
    return n;
  endfunction

endpackage

`default_nettype wire

@@ rtl/dfhe_front.sv @@
// Front end: accepts symbols, range-checks them and turns each in-range one into a queue entry
// of LSB-first bits. Depends on dfhe_pkg.
`default_nettype none

module dfhe_front import dfhe_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic [2:0]  in_symbol_kind,
  input  wire logic [15:0] in_symbol_value,
  input  wire logic [31:0] in_adler_checksum,
  input  wire logic        q_full,
  output logic             in_stall,
  output logic             push,
  output entry_t           push_entry
);

  logic        err_r, err_nxt;
  logic        accept;
  logic        bad;

  // literal
  logic [8:0]  lit_code;
  logic [3:0]  lit_len;
  logic [8:0]  lit_rev;

  // match length
  logic [15:0] len_diff;
  logic [7:0]  ls;
  logic [4:0]  lbw;
  logic [2:0]  lx_raw, lx;
  logic [7:0]  lsh;
  logic [8:0]  lcode_raw, lcode, hcode;
  logic [3:0]  hlen;
  logic [8:0]  hbits;
  logic [7:0]  lmask;
  logic [BITS_W-1:0] lbits;
  logic [LEN_W-1:0]  llen;

  // match distance
  logic [15:0] dist_diff;
  logic [14:0] ds;
  logic [4:0]  dbw;
  logic [3:0]  dx;
  logic [14:0] dsh;
  logic [4:0]  dcode;
  logic [8:0]  dh;
  logic [14:0] dmask;
  logic [BITS_W-1:0] dbits;
  logic [LEN_W-1:0]  dlen;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    lit_code = (in_symbol_value <= 16'd143) ? 9'd48 + in_symbol_value[8:0]
                                            : 9'd400 + (in_symbol_value[8:0] - 9'd144);
    lit_len  = (in_symbol_value <= 16'd143) ? 4'd8 : 4'd9;
    lit_rev  = rev9(lit_code) >> (4'd9 - lit_len);
  end

  always_comb begin
    len_diff  = in_symbol_value - 16'd3;
    ls        = len_diff[7:0];
    lbw       = bit_len16({8'd0, ls});
    lx_raw    = (lbw > 5'd3) ? 3'(lbw - 5'd3) : 3'd0;
    lsh       = ls >> lx_raw;
    lcode_raw = 9'd257 + {7'd0, lsh[1:0]} + {4'd0, lx_raw, 2'b00}
              + ((ls >= 8'd4) ? 9'd4 : 9'd0);
    // length 258 has its own code and no extra bits
    if (in_symbol_value == 16'd258) begin
      lcode = 9'd285;
      lx    = 3'd0;
    end else begin
      lcode = lcode_raw;
      lx    = lx_raw;
    end
    if (lcode <= 9'd279) begin
      hcode = lcode - 9'd256;
      hlen  = 4'd7;
    end else begin
      hcode = lcode - 9'd88;  // 192 + (code - 280)
      hlen  = 4'd8;
    end
    hbits = rev9(hcode) >> (4'd9 - hlen);
    lmask = (8'd1 << lx) - 8'd1;
    lbits = {9'd0, hbits} | ({10'd0, ls & lmask} << hlen);
    llen  = {1'b0, hlen} + {2'd0, lx};
  end

  always_comb begin
    dist_diff = in_symbol_value - 16'd1;
    ds        = dist_diff[14:0];
    dbw       = bit_len16({1'b0, ds});
    dx        = (dbw > 5'd2) ? 4'(dbw - 5'd2) : 4'd0;
    dsh       = ds >> dx;
    dcode     = {4'd0, dsh[0]} + {dx, 1'b0} + ((ds >= 15'd2) ? 5'd2 : 5'd0);
    dh        = rev9({4'd0, dcode}) >> 4;
    dmask     = (15'd1 << dx) - 15'd1;
    dbits     = {13'd0, dh[4:0]} | ({3'd0, ds & dmask} << 5);
    dlen      = 5'd5 + {1'b0, dx};
  end

  always_comb begin
    bad              = 1'b0;
    push_entry.op    = OP_BITS;
    push_entry.bits  = '0;
    push_entry.len   = '0;
    push_entry.err   = err_r;
    push_entry.adler = in_adler_checksum;
    unique case (in_symbol_kind)
      KIND_START: begin
        push_entry.op = OP_START;
      end
      KIND_LITERAL: begin
        bad             = in_symbol_value > 16'd255;
        push_entry.bits = {9'd0, lit_rev};
        push_entry.len  = {1'b0, lit_len};
      end
      KIND_LENGTH: begin
        bad             = (in_symbol_value < 16'd3) || (in_symbol_value > 16'd258);
        push_entry.bits = lbits;
        push_entry.len  = llen;
      end
      KIND_DISTANCE: begin
        bad             = (in_symbol_value < 16'd1) || (in_symbol_value > 16'd32768);
        push_entry.bits = dbits;
        push_entry.len  = dlen;
      end
      KIND_FINISH: begin
        push_entry.op = OP_FINISH;
      end
      default: begin
        bad = 1'b1;
      end
    endcase
  end

  assign push    = accept && !bad;
  assign err_nxt = err_r | (accept && bad);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      err_r <= 1'b0;
    end else begin
      err_r <= err_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/dfhe_queue.sv @@
// Short register queue of encoded symbols between front and back end.
// Depends on dfhe_pkg.
`default_nettype none

module dfhe_queue import dfhe_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     push,
  input  wire entry_t                   wr_entry,
  input  wire logic                     pop,
  output entry_t                        rd_entry,
  output logic                          full,
  output logic                          empty,
  output logic [$clog2(DEPTH+1)-1:0]    level
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LVL_W = $clog2(DEPTH + 1);

  entry_t             slots_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [LVL_W-1:0]   cnt_r, cnt_nxt;
  logic               do_push, do_pop;

  assign full     = cnt_r == LVL_W'(DEPTH);
  assign empty    = cnt_r == '0;
  assign level    = cnt_r;
  assign rd_entry = slots_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    cnt_nxt = cnt_r + LVL_W'(do_push) - LVL_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= wr_entry;
    end
  end

endmodule

`default_nettype wire

@@ rtl/dfhe_back.sv @@
// Back end: bit packer that merges queued symbols into bytes, emits the zlib
// header, the final flush and the Adler-32 trailer. Depends on dfhe_pkg.
`default_nettype none

module dfhe_back import dfhe_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire entry_t      head,
  input  wire logic        q_empty,
  output logic             pop,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_byte,
  output logic             out_last_byte,
  output logic             out_error_seen
);

  typedef enum logic [1:0] {
    ST_RUN,
    ST_HDR,
    ST_FLUSH,
    ST_ADLER
  } state_t;

  state_t            state_r, state_nxt;
  logic [ACC_W-1:0]  acc_r, acc_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              err_r, err_nxt;
  logic [31:0]       adler_r, adler_nxt;
  logic [1:0]        idx_r, idx_nxt;
  logic              out_vld_r, out_vld_nxt;
  logic [7:0]        byte_r, byte_nxt;
  logic              last_r, last_nxt;
  logic              oerr_r, oerr_nxt;

  logic              out_load;
  logic              emit;
  logic [7:0]        emit_byte;
  logic              emit_last;
  logic              emit_err;
  logic [ACC_W-1:0]  sum;
  logic [CNT_W-1:0]  csum;
  logic [7:0]        adler_byte;

  assign out_load = !out_vld_r || !out_stall;
  assign sum      = acc_r | ({7'd0, head.bits} << cnt_r[2:0]);
  assign csum     = cnt_r + head.len;

  always_comb begin
    case (idx_r)
      2'd0:    adler_byte = adler_r[31:24];
      2'd1:    adler_byte = adler_r[23:16];
      2'd2:    adler_byte = adler_r[15:8];
      default: adler_byte = adler_r[7:0];
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    acc_nxt   = acc_r;
    cnt_nxt   = cnt_r;
    err_nxt   = err_r;
    adler_nxt = adler_r;
    idx_nxt   = idx_r;
    pop       = 1'b0;
    emit      = 1'b0;
    emit_byte = acc_r[7:0];
    emit_last = 1'b0;
    emit_err  = err_r;

    unique case (state_r)
      ST_RUN: begin
        if (cnt_r >= CNT_W'(8)) begin
          // drain whole bytes left by the previous symbol
          if (out_load) begin
            emit    = 1'b1;
            acc_nxt = acc_r >> 8;
            cnt_nxt = cnt_r - CNT_W'(8);
          end
        end else if (!q_empty) begin
          unique case (head.op)
            OP_BITS: begin
              pop      = 1'b1;
              err_nxt  = head.err;
              emit_err = head.err;
              if (csum >= CNT_W'(8) && out_load) begin
                emit      = 1'b1;
                emit_byte = sum[7:0];
                acc_nxt   = sum >> 8;
                cnt_nxt   = csum - CNT_W'(8);
              end else begin
                acc_nxt = sum;
                cnt_nxt = csum;
              end
            end
            OP_START: begin
              // drop any partial byte and open a fresh stream
              if (out_load) begin
                pop       = 1'b1;
                emit      = 1'b1;
                emit_byte = ZLIB_CMF;
                err_nxt   = head.err;
                emit_err  = head.err;
                acc_nxt   = BLOCK_HDR_BITS;
                cnt_nxt   = BLOCK_HDR_LEN;
                state_nxt = ST_HDR;
              end
            end
            OP_FINISH: begin
              pop       = 1'b1;
              err_nxt   = head.err;
              adler_nxt = head.adler;
              cnt_nxt   = cnt_r + EOB_LEN;
              state_nxt = ST_FLUSH;
            end
            default: begin
              pop = 1'b1;
            end
          endcase
        end
      end
      ST_HDR: begin
        if (out_load) begin
          emit      = 1'b1;
          emit_byte = ZLIB_FLG;
          state_nxt = ST_RUN;
        end
      end
      ST_FLUSH: begin
        if (cnt_r >= CNT_W'(8)) begin
          if (out_load) begin
            emit    = 1'b1;
            acc_nxt = acc_r >> 8;
            cnt_nxt = cnt_r - CNT_W'(8);
          end
        end else if (cnt_r != '0) begin
          // pad the last partial byte with zeros
          if (out_load) begin
            emit    = 1'b1;
            acc_nxt = '0;
            cnt_nxt = '0;
          end
        end else begin
          idx_nxt   = 2'd0;
          state_nxt = ST_ADLER;
        end
      end
      ST_ADLER: begin
        if (out_load) begin
          emit      = 1'b1;
          emit_byte = adler_byte;
          emit_last = idx_r == 2'd3;
          idx_nxt   = idx_r + 2'd1;
          if (idx_r == 2'd3) begin
            acc_nxt   = '0;
            cnt_nxt   = '0;
            state_nxt = ST_RUN;
          end
        end
      end
      default: begin
        state_nxt = ST_RUN;
      end
    endcase

    out_vld_nxt = out_vld_r;
    byte_nxt    = byte_r;
    last_nxt    = last_r;
    oerr_nxt    = oerr_r;
    if (emit) begin
      out_vld_nxt = 1'b1;
      byte_nxt    = emit_byte;
      last_nxt    = emit_last;
      oerr_nxt    = emit_err;
    end else if (!out_stall) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_RUN;
      acc_r     <= '0;
      cnt_r     <= '0;
      err_r     <= 1'b0;
      idx_r     <= 2'd0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      acc_r     <= acc_nxt;
      cnt_r     <= cnt_nxt;
      err_r     <= err_nxt;
      idx_r     <= idx_nxt;
      out_vld_r <= out_vld_nxt;
    end
    adler_r <= adler_nxt;
    byte_r  <= byte_nxt;
    last_r  <= last_nxt;
    oerr_r  <= oerr_nxt;
  end

  assign out_valid      = out_vld_r;
  assign out_byte       = byte_r;
  assign out_last_byte  = last_r;
  assign out_error_seen = oerr_r;

endmodule

`default_nettype wire

@@ rtl/deflate_fixed_huffman_encoder.sv @@
// Top level of the zlib / fixed-Huffman DEFLATE encoder.
// Instantiates dfhe_front, dfhe_queue and dfhe_back; depends on dfhe_pkg.
//
// Usage: feed LZ77 symbols on the in_ channel (kind, value, Adler-32 on
// finish), one transaction each; take the compressed stream one byte per
// transaction on the out_ channel. out_last_byte marks the final trailer byte,
// out_error_seen reports the sticky out-of-range flag as of that byte.
// Send start first, then literals / length-distance pairs, then finish.
// With the queue empty, the first byte of a symbol passes the queue slot
// register and then the packer's output register before it is on out_byte.
// The bit packer emits one byte per cycle while out_stall is low; a symbol
// completes up to 3 bytes for a distance and 2 for start; finish takes one
// step to queue end-of-block, up to two flush bytes, one idle step and four
// trailer bytes.
// A queue of QUEUE_DEPTH symbols sits between the encoder and the packer;
// in_stall rises only when it is full.
// Reset clears the bit queue, error flags, queue and the output valid flag.
// While out_stall is high a valid output byte holds and the packer emits no
// new byte; the front keeps accepting symbols until the queue fills.
`default_nettype none

module deflate_fixed_huffman_encoder import dfhe_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  in_symbol_kind,
  input  wire logic [15:0] in_symbol_value,
  input  wire logic [31:0] in_adler_checksum,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_byte,
  output logic             out_last_byte,
  output logic             out_error_seen
);

  localparam int LVL_W = $clog2(QUEUE_DEPTH + 1);

  entry_t             push_entry;
  entry_t             head;
  logic               push;
  logic               pop;
  logic               q_full;
  logic               q_empty;
  logic [LVL_W-1:0]   q_level;

  dfhe_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_symbol_kind    (in_symbol_kind),
    .in_symbol_value   (in_symbol_value),
    .in_adler_checksum (in_adler_checksum),
    .q_full            (q_full),
    .in_stall          (in_stall),
    .push              (push),
    .push_entry        (push_entry)
  );

  dfhe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .wr_entry (push_entry),
    .pop      (pop),
    .rd_entry (head),
    .full     (q_full),
    .empty    (q_empty),
    .level    (q_level)
  );

  dfhe_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head           (head),
    .q_empty        (q_empty),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_last_byte  (out_last_byte),
    .out_error_seen (out_error_seen)
  );

`ifndef SYNTHESIS
  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_level <= LVL_W'(QUEUE_DEPTH))
    else $error("queue level exceeds depth");

  a_out_idle_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !out_valid)
    else $error("output valid right after reset");

  a_last_not_twice: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_byte && !out_stall |=> !(out_valid && out_last_byte))
    else $error("two trailer end bytes in a row");

  a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && out_valid && $past(out_valid && out_error_seen) |-> out_error_seen)
    else $error("error flag dropped on a later byte");
`endif

endmodule

`default_nettype wire

@@ tb/dfhe_stream_checker.sv @@
`timescale 1ns / 100ps
// Stream checker for the fixed-Huffman DEFLATE encoder: predicts the zlib byte
// stream from accepted symbol transactions and compares it with the output channel.
// Depends on dfhe_pkg for the symbol kind codes.

module dfhe_stream_checker import dfhe_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic        in_stall,
  input  wire logic [2:0]  in_symbol_kind,
  input  wire logic [15:0] in_symbol_value,
  input  wire logic [31:0] in_adler_checksum,
  input  wire logic        out_valid,
  input  wire logic        out_stall,
  input  wire logic [7:0]  out_byte,
  input  wire logic        out_last_byte,
  input  wire logic        out_error_seen,
  output int               mismatches,
  output int               bytes_due
);

  localparam logic [7:0] CMF_BYTE  = 8'h78;
  localparam logic [7:0] FLG_BYTE  = 8'h5E;
  localparam logic [8:0] BLOCK_HDR = 9'b110;  // BFINAL=1, BTYPE=01, sent MSB first
  localparam int         SHOWN_MAX = 10;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       err;
  } zbyte_t;

  zbyte_t      zlib_bytes_due[$];
  logic [31:0] bitq;
  int unsigned bitq_n;
  logic        sticky_err;
  int          err_total = 0;

  function automatic int unsigned sig_bits(input logic [15:0] v);
    int unsigned n;
    n = 0;
    for (int i = 0; i < 16; i++) begin
      if (v[i]) begin
        n = i + 1;
      end
    end
    return n;
  endfunction

  task automatic queue_msb(input logic [8:0] code, input int unsigned n);
    for (int i = int'(n) - 1; i >= 0; i--) begin
      bitq[bitq_n] = code[i];
      bitq_n++;
    end
  endtask

  task automatic queue_lsb(input logic [15:0] v, input int unsigned n);
    for (int i = 0; i < int'(n); i++) begin
      bitq[bitq_n] = v[i];
      bitq_n++;
    end
  endtask

  task automatic emit_byte(input logic [7:0] b, input logic last);
    zbyte_t z;
    z.data = b;
    z.last = last;
    z.err  = sticky_err;
    zlib_bytes_due = {zlib_bytes_due, z};
  endtask

  task automatic pack_whole_bytes();
    while (bitq_n >= 8) begin
      emit_byte(bitq[7:0], 1'b0);
      bitq   = bitq >> 8;
      bitq_n = bitq_n - 8;
    end
  endtask

  // Codes 257..279 are 7 bits, 280..287 are 8 bits starting at 192.
  task automatic queue_len_code(input int unsigned code);
    if (code <= 279) begin
      queue_msb(9'(code - 256), 7);
    end else begin
      queue_msb(9'(192 + code - 280), 8);
    end
  endtask

  task automatic encode_symbol(input logic [2:0] kind, input logic [15:0] value,
                               input logic [31:0] adler);
    int unsigned s;
    int unsigned w;
    int unsigned x;
    int unsigned code;
    case (kind)
      KIND_START: begin
        bitq   = '0;
        bitq_n = 0;
        emit_byte(CMF_BYTE, 1'b0);
        emit_byte(FLG_BYTE, 1'b0);
        queue_msb(BLOCK_HDR, 3);
      end
      KIND_LITERAL: begin
        if (value > 255) begin
          sticky_err = 1'b1;
        end else if (value <= 143) begin
          queue_msb(9'(48 + value), 8);
        end else begin
          queue_msb(9'(400 + value - 144), 9);
        end
      end
      KIND_LENGTH: begin
        if (value < 3 || value > 258) begin
          sticky_err = 1'b1;
        end else if (value == 258) begin
          queue_len_code(285);
        end else begin
          s    = value - 3;
          w    = sig_bits(16'(s));
          x    = (w > 3) ? w - 3 : 0;
          code = ((s >> x) & 3) + 4 * x + ((s >= 4) ? 4 : 0) + 257;
          queue_len_code(code);
          queue_lsb(16'(s), x);
        end
      end
      KIND_DISTANCE: begin
        if (value < 1 || value > 32768) begin
          sticky_err = 1'b1;
        end else begin
          s    = value - 1;
          w    = sig_bits(16'(s));
          x    = (w > 2) ? w - 2 : 0;
          code = ((s >> x) & 1) + 2 * x + ((s >= 2) ? 2 : 0);
          queue_msb(9'(code), 5);
          queue_lsb(16'(s), x);
        end
      end
      KIND_FINISH: begin
        queue_len_code(256);
        pack_whole_bytes();
        // pad the partial byte with zeros
        if (bitq_n > 0) begin
          emit_byte(bitq[7:0], 1'b0);
        end
        bitq   = '0;
        bitq_n = 0;
        emit_byte(adler[31:24], 1'b0);
        emit_byte(adler[23:16], 1'b0);
        emit_byte(adler[15:8], 1'b0);
        emit_byte(adler[7:0], 1'b1);
      end
      default: begin
        sticky_err = 1'b1;
      end
    endcase
    pack_whole_bytes();
    bitq = bitq & 32'h01FF_FFFF;
  endtask

  always @(posedge clk) begin
    zbyte_t due;
    if (!rst_n) begin
      bitq       = '0;
      bitq_n     = 0;
      sticky_err = 1'b0;
      zlib_bytes_due.delete();
    end else begin
      if (in_valid && !in_stall) begin
        encode_symbol(in_symbol_kind, in_symbol_value, in_adler_checksum);
      end
      if (out_valid && !out_stall) begin
        if (zlib_bytes_due.size() == 0) begin
          err_total++;
          if (err_total <= SHOWN_MAX) begin
            $display("%0t: unexpected byte %02h last=%0b err=%0b", $realtime,
                     out_byte, out_last_byte, out_error_seen);
          end
        end else begin
          due = zlib_bytes_due.pop_front();
          if (due.data !== out_byte || due.last !== out_last_byte ||
              due.err !== out_error_seen) begin
            err_total++;
            if (err_total <= SHOWN_MAX) begin
              $display({"%0t: byte mismatch: expected %02h last=%0b err=%0b,",
                        " got %02h last=%0b err=%0b"},
                       $realtime, due.data, due.last, due.err,
                       out_byte, out_last_byte, out_error_seen);
            end
          end
        end
      end
    end
    mismatches <= err_total;
    bytes_due  <= zlib_bytes_due.size();
  end

endmodule

@@ tb/tb_deflate_fixed_huffman_encoder.sv @@
`timescale 1ns / 100ps
// Testbench top for deflate_fixed_huffman_encoder: drives symbol streams with
// bursty input and varied output stalls; checking lives in dfhe_stream_checker.

module tb_deflate_fixed_huffman_encoder;
  import dfhe_pkg::*;

  localparam logic [2:0] KIND_RSVD_LO = 3'd5;
  localparam logic [2:0] KIND_RSVD_HI = 3'd7;
  localparam int STREAM_ITEMS  = 380;
  localparam int PRESSURE_AT   = 150;
  localparam int HOLD_CYCLES   = 80;
  localparam int IDLE_LIMIT    = 2000;
  localparam int SETTLE_CYCLES = 12;

  typedef enum logic [1:0] {
    RX_FREE,
    RX_LIGHT,
    RX_HEAVY,
    RX_PERIODIC
  } rx_mode_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic [2:0]  in_symbol_kind = '0;
  logic [15:0] in_symbol_value = '0;
  logic [31:0] in_adler_checksum = '0;
  logic        out_stall = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic [7:0]  out_byte;
  logic        out_last_byte;
  logic        out_error_seen;
  int          mismatches;
  int          bytes_due;

  int          burst_left = 0;
  int          items_sent = 0;
  int          hold_requests = 0;

  deflate_fixed_huffman_encoder dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_symbol_kind    (in_symbol_kind),
    .in_symbol_value   (in_symbol_value),
    .in_adler_checksum (in_adler_checksum),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_byte          (out_byte),
    .out_last_byte     (out_last_byte),
    .out_error_seen    (out_error_seen)
  );

  dfhe_stream_checker stream_chk (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_symbol_kind    (in_symbol_kind),
    .in_symbol_value   (in_symbol_value),
    .in_adler_checksum (in_adler_checksum),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_byte          (out_byte),
    .out_last_byte     (out_last_byte),
    .out_error_seen    (out_error_seen),
    .mismatches        (mismatches),
    .bytes_due         (bytes_due)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Receiver: switch between random stall patterns; serve long hold-offs on request.
  always @(negedge clk) begin
    static rx_mode_t mode = RX_FREE;
    static int mode_left = 0;
    static int hold_left = 0;
    static int hold_served = 0;
    static int phase = 0;
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left   = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        mode      = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 100);
      end
      mode_left--;
      phase++;
      case (mode)
        RX_FREE:     out_stall <= 1'b0;
        RX_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
        RX_HEAVY:    out_stall <= ($urandom_range(0, 3) != 0);
        RX_PERIODIC: out_stall <= ((phase % 5) < 2);
        default:     out_stall <= 1'b0;
      endcase
    end
  end

  // Watchdog: end the run when no transaction moves for too long.
  always @(posedge clk) begin
    static int idle_cycles = 0;
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("deflate_fixed_huffman_encoder test failed");
        $finish;
      end
    end
  end

  // Offer one symbol and wait for its transaction; count every item sent.
  task automatic offer(input logic [2:0] kind, input logic [15:0] value,
                       input logic [31:0] adler, input bit steady);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = steady ? 0 : $urandom_range(0, 5);
      repeat (gap) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid          <= 1'b1;
    in_symbol_kind    <= kind;
    in_symbol_value   <= value;
    in_adler_checksum <= adler;
    do begin
      @(posedge clk);
    end while (in_stall);
    items_sent++;
  endtask

  // One stream: start, literals and length/distance pairs, finish; now and then
  // drop the start or the finish, or slip in a random symbol.
  task automatic send_stream(input bit steady);
    int n;
    int pick;
    int w;
    logic [15:0] v;
    n = $urandom_range(1, 24);
    if ($urandom_range(0, 9) != 0) begin
      offer(KIND_START, 16'($urandom), $urandom, steady);
    end
    repeat (n) begin
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
        offer(3'($urandom_range(0, 7)), 16'($urandom), $urandom, steady);
      end else if (pick < 60) begin
        offer(KIND_LITERAL, 16'($urandom_range(0, 255)), $urandom, steady);
      end else begin
        v = ($urandom_range(0, 7) == 0) ? 16'd258 : 16'($urandom_range(3, 258));
        offer(KIND_LENGTH, v, $urandom, steady);
        w = $urandom_range(0, 15);
        v = 16'($urandom_range(1 << w, (w == 15) ? 32768 : (2 << w)));
        offer(KIND_DISTANCE, v, $urandom, steady);
      end
    end
    if ($urandom_range(0, 9) != 0) begin
      offer(KIND_FINISH, 16'($urandom), $urandom, steady);
    end
  endtask

  initial begin
    bit pressed;
    pressed = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // symbol ahead of any start, then one clean stream over the code edges
    offer(KIND_LITERAL, 16'd200, 32'h0, 1'b0);
    offer(KIND_START, 16'd0, 32'h0, 1'b0);
    offer(KIND_LITERAL, 16'd0, 32'h0, 1'b0);
    offer(KIND_LITERAL, 16'd143, 32'h0, 1'b0);
    offer(KIND_LITERAL, 16'd144, 32'h0, 1'b0);
    offer(KIND_LITERAL, 16'd255, 32'h0, 1'b0);
    offer(KIND_LENGTH, 16'd3, 32'h0, 1'b0);
    offer(KIND_LENGTH, 16'd10, 32'h0, 1'b0);
    offer(KIND_LENGTH, 16'd11, 32'h0, 1'b0);
    offer(KIND_LENGTH, 16'd257, 32'h0, 1'b0);
    offer(KIND_LENGTH, 16'd258, 32'h0, 1'b0);
    offer(KIND_DISTANCE, 16'd1, 32'h0, 1'b0);
    offer(KIND_DISTANCE, 16'd2, 32'h0, 1'b0);
    offer(KIND_DISTANCE, 16'd5, 32'h0, 1'b0);
    offer(KIND_DISTANCE, 16'd32768, 32'h0, 1'b0);
    offer(KIND_FINISH, 16'd0, 32'hFFFF_FFFF, 1'b0);
    // out-of-range values and reserved kinds: drop, raise the sticky flag
    offer(KIND_LITERAL, 16'd256, 32'h0, 1'b0);
    offer(KIND_LENGTH, 16'd2, 32'h0, 1'b0);
    offer(KIND_LENGTH, 16'd259, 32'h0, 1'b0);
    offer(KIND_DISTANCE, 16'd0, 32'h0, 1'b0);
    offer(KIND_DISTANCE, 16'hFFFF, 32'h0, 1'b0);
    offer(KIND_RSVD_LO, 16'd1, 32'h0, 1'b0);
    offer(KIND_RSVD_HI, 16'd1, 32'h0, 1'b0);
    offer(KIND_START, 16'd0, 32'h0, 1'b0);
    offer(KIND_FINISH, 16'd0, 32'h0, 1'b0);

    while (items_sent < STREAM_ITEMS) begin
      if (!pressed && items_sent >= PRESSURE_AT) begin
        // hold off the receiver while the sender keeps pushing
        pressed = 1'b1;
        hold_requests++;
        send_stream(1'b1);
      end else begin
        send_stream(1'b0);
      end
    end
    @(negedge clk);
    in_valid <= 1'b0;

    while (bytes_due != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatches == 0 && bytes_due == 0) begin
      $display("deflate_fixed_huffman_encoder test passed");
    end else begin
      $display("deflate_fixed_huffman_encoder test failed");
    end
    $finish;
  end

endmodule
